[rtl/wheel_slip_traction_limiter_top_macros.svh]
// Assertion macros used by the traction limiter checker.
`ifndef WHEEL_SLIP_TRACTION_LIMITER_TOP_MACROS_SVH
`define WHEEL_SLIP_TRACTION_LIMITER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WSTL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wstl: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WSTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wstl: assertion failed");

`endif

[rtl/wstl_pkg.sv]
// Types, codes and constants of the wheel slip traction limiter.
`timescale 1ns / 1ps
`default_nettype none

package wstl_pkg;

    localparam int MOTORS   = 4;
    localparam int MIDX_W   = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    // quotient bits produced by the serial divider
    localparam int DIV_BITS = 20;
    localparam int DCNT_W   = $clog2(DIV_BITS);

    typedef enum logic [1:0] {
        ACT_UPDATE = 2'd0,
        ACT_RAISE  = 2'd1,
        ACT_LOWER  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    localparam logic [1:0] AXLE_FRONT = 2'd0;
    localparam logic [1:0] AXLE_REAR  = 2'd1;

    localparam logic [2:0] REG_SLIP_LIMIT_FRONT = 3'd0;
    localparam logic [2:0] REG_SLIP_LIMIT_REAR  = 3'd1;
    localparam logic [2:0] REG_PROP_GAIN_FRONT  = 3'd2;
    localparam logic [2:0] REG_DERIV_GAIN_FRONT = 3'd3;
    localparam logic [2:0] REG_PROP_GAIN_REAR   = 3'd4;
    localparam logic [2:0] REG_DERIV_GAIN_REAR  = 3'd5;

    localparam logic [15:0] SLIP_LIMIT_RESET = 16'd1600;
    localparam logic [15:0] PROP_GAIN_RESET  = 16'd256;
    localparam logic [15:0] DERIV_GAIN_RESET = 16'd0;

    localparam logic [6:0]  PCT_FULL   = 7'd100;
    localparam logic [10:0] SLIP_SCALE = 11'd1600;

    localparam logic signed [19:0] SLIP_MAX = 20'sh7FFFF;
    localparam logic signed [19:0] SLIP_MIN = 20'sh80000;
    localparam logic [19:0] SLIP_MAX_MAG    = 20'd524287;
    localparam logic [20:0] SLIP_MIN_MAG    = 21'd524288;

    // floor(t/3) > 100 exactly when t >= 303; below that t*683 >> 11 is floor(t/3)
    localparam logic [8:0] DRIVE_SAT_T  = 9'd303;
    localparam logic [9:0] DIV3_RECIP   = 10'd683;
    localparam logic [7:0] DRIVE_OVER   = 8'd101;
    localparam logic [6:0] THR_PCT_MULT = 7'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_PROD_LO,
        ST_PROD_HI,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic mul;
        logic sum;
        logic prod_lo;
        logic prod_hi;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic is_update;
        logic div_run;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/wstl_ctrl.sv]
// Sequencer of the traction limiter: item flow, divider count, output valid.
`timescale 1ns / 1ps
`default_nettype none

module wstl_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output wstl_pkg::dp_cmd_t         cmd,
    input  wire wstl_pkg::dp_status_t status
);
    import wstl_pkg::*;

    state_t              state_reg, state_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                if (!status.is_update)
                    state_next = ST_FIN;
                else if (status.div_run)
                    state_next = ST_DIV;
                else
                    state_next = ST_MUL;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIV_BITS - 1))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_PROD_LO;
            end
            ST_PROD_LO:
            begin
                cmd.prod_lo = 1'b1;
                state_next  = ST_PROD_HI;
            end
            ST_PROD_HI:
            begin
                cmd.prod_hi = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                // result register must be free or emptying this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/wstl_dp.sv]
// Datapath of the traction limiter: registers, slip divider, PD products, drive.
`timescale 1ns / 1ps
`default_nettype none

module wstl_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire wstl_pkg::dp_cmd_t    cmd,
    output wstl_pkg::dp_status_t      status,
    input  wire logic                 cfg_valid,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic [1:0]           action,
    input  wire logic [1:0]           motor_index,
    input  wire logic signed [15:0]   vehicle_speed,
    input  wire logic signed [15:0]   wheel_speed,
    input  wire logic [1:0]           wheel_axle,
    input  wire logic [13:0]          throttle_volts,
    input  wire logic [7:0]           amount,
    output logic [1:0]                out_motor,
    output logic [6:0]                drive_level,
    output logic signed [19:0]        slip_percent,
    output logic                      control_active,
    output logic [6:0]                cap_percent
);
    import wstl_pkg::*;

    // configuration
    logic [15:0] limit_f_reg, limit_r_reg;
    logic [15:0] kp_f_reg, kd_f_reg, kp_r_reg, kd_r_reg;

    // per-motor state
    logic signed [16:0] prev_err_reg [MOTORS];
    logic [6:0]         cap_reg      [MOTORS];

    // captured item
    action_t            act_reg;
    logic [1:0]         m_reg;
    logic signed [15:0] veh_reg, whl_reg;
    logic [1:0]         axle_reg;
    logic [13:0]        thr_reg;
    logic [7:0]         amt_reg;

    // divider
    logic [14:0]        rem_reg;
    logic [19:0]        q_reg;
    logic               ovf_reg, neg_reg, vpos_reg;

    // products and sums
    logic signed [19:0] slip_reg;
    logic signed [16:0] err_reg;
    logic signed [33:0] prod_p_reg;
    logic signed [34:0] prod_d_reg;
    logic signed [35:0] sum_reg;
    logic               active_reg;
    logic [31:0]        p_lo_reg;
    logic signed [50:0] p_reg;

    // result register
    logic [1:0]         out_motor_reg;
    logic [6:0]         level_reg;
    logic signed [19:0] slip_out_reg;
    logic               active_out_reg;
    logic [6:0]         cap_out_reg;

    logic [MIDX_W-1:0]  m_idx;
    logic               motor_ok;
    logic               vpos;
    logic signed [27:0] num;
    logic [27:0]        num_abs;
    logic               ovf;

    assign m_idx    = MIDX_W'(m_reg);
    assign motor_ok = int'(m_reg) < MOTORS;
    assign vpos     = !veh_reg[15] && (veh_reg != 16'sd0);
    assign num      = 28'(whl_reg) * $signed(28'(SLIP_SCALE));
    assign num_abs  = num[27] ? 28'(-num) : 28'(num);
    // quotient would not fit the divider's bits: slip saturates
    assign ovf      = {9'b0, num_abs[25:20]} >= veh_reg[14:0];

    assign status.is_update = (act_reg == ACT_UPDATE) && motor_ok;
    assign status.div_run   = vpos && !ovf;

    // one restoring step
    logic [15:0] trial, diff;
    logic        ge;
    assign trial = {rem_reg, q_reg[19]};
    assign diff  = trial - {1'b0, veh_reg[14:0]};
    assign ge    = trial >= {1'b0, veh_reg[14:0]};

    // floor and saturation of the slip quotient
    logic signed [19:0] slip_calc;
    logic [20:0]        neg_mag;
    assign neg_mag = {1'b0, q_reg} + 21'(rem_reg != 15'd0);

    always_comb
    begin
        if (!vpos_reg)
            slip_calc = '0;
        else if (ovf_reg)
            slip_calc = neg_reg ? SLIP_MIN : SLIP_MAX;
        else if (!neg_reg)
            slip_calc = (q_reg > SLIP_MAX_MAG) ? SLIP_MAX : $signed(q_reg);
        else
            slip_calc = (neg_mag > SLIP_MIN_MAG) ? SLIP_MIN : $signed(20'(-neg_mag));
    end

    // PD terms
    logic               rear;
    logic [15:0]        kp_sel, kd_sel, limit_sel;
    logic signed [16:0] err, prev, kp_s, kd_s;
    logic signed [17:0] der;
    logic signed [33:0] pp;
    logic signed [34:0] pd;

    assign rear      = (axle_reg == AXLE_REAR);
    assign kp_sel    = rear ? kp_r_reg : kp_f_reg;
    assign kd_sel    = rear ? kd_r_reg : kd_f_reg;
    assign limit_sel = rear ? limit_r_reg : limit_f_reg;
    assign err       = 17'(whl_reg) - 17'(veh_reg);
    assign prev      = prev_err_reg[m_idx];
    assign der       = 18'(err) - 18'(prev);
    assign kp_s      = $signed({1'b0, kp_sel});
    assign kd_s      = $signed({1'b0, kd_sel});
    assign pp        = kp_s * err;
    assign pd        = kd_s * der;

    logic active;
    assign active = (axle_reg inside {AXLE_FRONT, AXLE_REAR})
                    && ($signed({slip_reg[19], slip_reg}) < $signed({5'b0, limit_sel}));

    // throttle times PD sum, split into low and high partial products
    logic [31:0]        p_lo_next;
    logic signed [32:0] p_hi;
    logic signed [14:0] thr_s;
    logic signed [50:0] p_next;
    assign thr_s     = $signed({1'b0, thr_reg});
    assign p_lo_next = 32'(thr_reg) * 32'(sum_reg[17:0]);
    assign p_hi      = thr_s * $signed(sum_reg[35:18]);
    assign p_next    = $signed((51'(p_hi) << 18) + 51'(p_lo_reg));

    // drive percent, limited by the motor cap
    logic [22:0] tt;
    logic [20:0] thr100;
    logic [8:0]  tu, t9;
    logic        sat, drv_neg;
    logic [18:0] q3;
    logic [7:0]  drive8;
    logic [6:0]  cap_cur, drive7, level;

    assign tt      = p_reg[50:28];
    assign thr100  = 21'(thr_reg) * 21'(THR_PCT_MULT);
    assign tu      = thr100[20:12];
    assign t9      = active_reg ? tt[8:0] : tu;
    assign sat     = active_reg ? (tt >= 23'(DRIVE_SAT_T)) : (tu >= DRIVE_SAT_T);
    assign drv_neg = active_reg && p_reg[50];
    assign q3      = 19'(t9) * 19'(DIV3_RECIP);
    assign drive8  = sat ? DRIVE_OVER : q3[18:11];
    assign cap_cur = cap_reg[m_idx];
    assign drive7  = drv_neg ? 7'd0
                   : (({1'b0, cap_cur} < drive8) ? cap_cur : drive8[6:0]);
    assign level   = PCT_FULL - drive7;

    // cap adjust
    logic [8:0] raised;
    logic [6:0] cap_new;
    assign raised = 9'(cap_cur) + 9'(amt_reg);

    always_comb
    begin
        case (act_reg)
            ACT_RAISE: cap_new = (raised > 9'(PCT_FULL)) ? PCT_FULL : raised[6:0];
            ACT_LOWER: cap_new = ({1'b0, cap_cur} > amt_reg) ? 7'(cap_cur - amt_reg[6:0])
                                                               : 7'd0;
            default:   cap_new = cap_cur;
        endcase
    end

    // configuration and per-motor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_f_reg <= SLIP_LIMIT_RESET;
            limit_r_reg <= SLIP_LIMIT_RESET;
            kp_f_reg    <= PROP_GAIN_RESET;
            kd_f_reg    <= DERIV_GAIN_RESET;
            kp_r_reg    <= PROP_GAIN_RESET;
            kd_r_reg    <= DERIV_GAIN_RESET;
            for (int i = 0; i < MOTORS; i++)
            begin
                prev_err_reg[i] <= '0;
                cap_reg[i]      <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SLIP_LIMIT_FRONT: limit_f_reg <= cfg_data;
                    REG_SLIP_LIMIT_REAR:  limit_r_reg <= cfg_data;
                    REG_PROP_GAIN_FRONT:  kp_f_reg    <= cfg_data;
                    REG_DERIV_GAIN_FRONT: kd_f_reg    <= cfg_data;
                    REG_PROP_GAIN_REAR:   kp_r_reg    <= cfg_data;
                    REG_DERIV_GAIN_REAR:  kd_r_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.commit && motor_ok)
            begin
                if (status.is_update)
                begin
                    if (active_reg)
                        prev_err_reg[m_idx] <= err_reg;
                end
                else
                begin
                    cap_reg[m_idx] <= cap_new;
                end
            end
        end
    end

    // item, divider and arithmetic pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action_t'(action);
            m_reg    <= motor_index;
            veh_reg  <= vehicle_speed;
            whl_reg  <= wheel_speed;
            axle_reg <= wheel_axle;
            thr_reg  <= throttle_volts;
            amt_reg  <= amount;
        end
        if (cmd.div_init)
        begin
            rem_reg  <= {9'b0, num_abs[25:20]};
            q_reg    <= num_abs[19:0];
            ovf_reg  <= ovf;
            neg_reg  <= whl_reg[15];
            vpos_reg <= vpos;
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? diff[14:0] : trial[14:0];
            q_reg   <= {q_reg[18:0], ge};
        end
        if (cmd.mul)
        begin
            slip_reg   <= slip_calc;
            err_reg    <= err;
            prod_p_reg <= pp;
            prod_d_reg <= pd;
        end
        if (cmd.sum)
        begin
            sum_reg    <= 36'(prod_p_reg) + 36'(prod_d_reg);
            active_reg <= active;
        end
        if (cmd.prod_lo)
            p_lo_reg <= p_lo_next;
        if (cmd.prod_hi)
            p_reg <= p_next;
        if (cmd.commit)
        begin
            out_motor_reg <= m_reg;
            if (status.is_update)
            begin
                level_reg      <= level;
                slip_out_reg   <= slip_reg;
                active_out_reg <= active_reg;
                cap_out_reg    <= cap_cur;
            end
            else
            begin
                level_reg      <= PCT_FULL;
                slip_out_reg   <= '0;
                active_out_reg <= 1'b0;
                cap_out_reg    <= motor_ok ? cap_new : 7'd0;
            end
        end
    end

    assign out_motor      = out_motor_reg;
    assign drive_level    = level_reg;
    assign slip_percent   = slip_out_reg;
    assign control_active = active_out_reg;
    assign cap_percent    = cap_out_reg;

endmodule

`default_nettype wire

[rtl/wheel_slip_traction_limiter_top.sv]
// Top level of the per-motor wheel slip traction limiter.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    action .. amount
//   out       source     out_valid / out_ready  out_motor .. cap_percent
//   cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time. Control update with positive vehicle speed and an
// unsaturated slip: check, bit-serial divider, multiply, sum, product low
// and high, finish. Other updates: no divider. Cap adjusts: check, finish.
// A result waits in the output register while the next beat is accepted;
// the finishing step holds while that register is still full.
// Reset clears cfg registers to defaults, motor caps and stored errors to 0.
`timescale 1ns / 1ps
`default_nettype none

module wheel_slip_traction_limiter_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           action,
    input  wire logic [1:0]           motor_index,
    input  wire logic signed [15:0]   vehicle_speed,
    input  wire logic signed [15:0]   wheel_speed,
    input  wire logic [1:0]           wheel_axle,
    input  wire logic [13:0]          throttle_volts,
    input  wire logic [7:0]           amount,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                out_motor,
    output logic [6:0]                drive_level,
    output logic signed [19:0]        slip_percent,
    output logic                      control_active,
    output logic [6:0]                cap_percent,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_data
);
    import wstl_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // registers accept a write every cycle
    assign cfg_ready = 1'b1;

    wstl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    wstl_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .action         (action),
        .motor_index    (motor_index),
        .vehicle_speed  (vehicle_speed),
        .wheel_speed    (wheel_speed),
        .wheel_axle     (wheel_axle),
        .throttle_volts (throttle_volts),
        .amount         (amount),
        .out_motor      (out_motor),
        .drive_level    (drive_level),
        .slip_percent   (slip_percent),
        .control_active (control_active),
        .cap_percent    (cap_percent)
    );

endmodule

`default_nettype wire

[rtl/wstl_checker.sv]
// Port-level checks of the traction limiter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "wheel_slip_traction_limiter_top_macros.svh"

module wstl_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [6:0]           drive_level,
    input wire logic signed [19:0]   slip_percent,
    input wire logic                 control_active,
    input wire logic [6:0]           cap_percent
);

    // levels and caps are percentages
    `WSTL_ASSERT_NOW(a_pct_range, out_valid, (drive_level <= 7'd100) && (cap_percent <= 7'd100))

    // drive never exceeds the cap, so level + cap reaches 100
    `WSTL_ASSERT_NOW(a_cap_limit, out_valid, (8'(drive_level) + 8'(cap_percent)) >= 8'd100)

    // control only runs below a 16-bit slip limit
    `WSTL_ASSERT_NOW(a_active_slip, out_valid && control_active, slip_percent < 20'sd65535)

    // one item in flight
    `WSTL_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

    `WSTL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(slip_percent))

endmodule

bind wheel_slip_traction_limiter_top wstl_checker u_wstl_checker (.*);

`default_nettype wire

[dv/wheel_slip_traction_limiter_top_tb.sv]
// Self-checking testbench for the wheel slip traction limiter top level.
`timescale 1ns / 1ps

module wheel_slip_traction_limiter_top_tb;
    import wstl_pkg::*;

    typedef struct packed {
        action_t            act;
        logic [1:0]         motor;
        logic signed [15:0] veh;
        logic signed [15:0] whl;
        logic [1:0]         axle;
        logic [13:0]        thr;
        logic [7:0]         amt;
    } traction_cmd_t;

    typedef struct packed {
        logic [1:0]  motor;
        logic [6:0]  level;
        logic [19:0] slip;
        logic        active;
        logic [6:0]  cap;
    } drive_result_t;

    localparam longint VOLT_FULL_SCALE = 12288;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] action;
    logic [1:0] motor_index;
    logic signed [15:0] vehicle_speed;
    logic signed [15:0] wheel_speed;
    logic [1:0] wheel_axle;
    logic [13:0] throttle_volts;
    logic [7:0] amount;
    logic out_valid;
    logic out_ready;
    logic [1:0] out_motor;
    logic [6:0] drive_level;
    logic signed [19:0] slip_percent;
    logic control_active;
    logic [6:0] cap_percent;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;

    // predictor state
    logic [15:0] limiter_regs [0:5];
    longint      stored_error [0:MOTORS-1];
    int          motor_cap    [0:MOTORS-1];

    drive_result_t expected_q[$];
    int mismatches;
    int burst_left;
    int sink_mode;
    int sink_left;
    int sink_tick;

    wheel_slip_traction_limiter_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .motor_index    (motor_index),
        .vehicle_speed  (vehicle_speed),
        .wheel_speed    (wheel_speed),
        .wheel_axle     (wheel_axle),
        .throttle_volts (throttle_volts),
        .amount         (amount),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_motor      (out_motor),
        .drive_level    (drive_level),
        .slip_percent   (slip_percent),
        .control_active (control_active),
        .cap_percent    (cap_percent),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint floor_quot(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    // Expected result of one beat; updates caps, stored errors.
    function automatic drive_result_t predict_traction(input traction_cmd_t c);
        drive_result_t r;
        longint veh, whl, slip, lim, err, der, kp, kd, gain_sum, thr, drv;
        r.motor  = c.motor;
        r.level  = PCT_FULL;
        r.slip   = '0;
        r.active = 1'b0;
        veh  = c.veh;
        whl  = c.whl;
        thr  = c.thr;
        slip = 0;
        case (c.act)
            ACT_UPDATE:
            begin
                if (veh > 0)
                begin
                    slip = floor_quot(1600 * whl, veh);
                    if (slip > 524287)
                        slip = 524287;
                    if (slip < -524288)
                        slip = -524288;
                end
                lim = (c.axle == AXLE_REAR) ? limiter_regs[REG_SLIP_LIMIT_REAR]
                                            : limiter_regs[REG_SLIP_LIMIT_FRONT];
                if ((c.axle == AXLE_FRONT || c.axle == AXLE_REAR) && slip < lim)
                begin
                    err = whl - veh;
                    der = err - stored_error[c.motor];
                    kp  = (c.axle == AXLE_REAR) ? limiter_regs[REG_PROP_GAIN_REAR]
                                                : limiter_regs[REG_PROP_GAIN_FRONT];
                    kd  = (c.axle == AXLE_REAR) ? limiter_regs[REG_DERIV_GAIN_REAR]
                                                : limiter_regs[REG_DERIV_GAIN_FRONT];
                    gain_sum = kp * err + kd * der;
                    drv = floor_quot(thr * gain_sum, VOLT_FULL_SCALE * 65536);
                    stored_error[c.motor] = err;
                    r.active = 1'b1;
                end
                else
                begin
                    drv = (thr * 100) / VOLT_FULL_SCALE;
                end
                if (drv < 0)
                    drv = 0;
                if (drv > 65535)
                    drv = 65535;
                if (drv > motor_cap[c.motor])
                    drv = motor_cap[c.motor];
                r.level = 7'(100 - drv);
                r.slip  = slip[19:0];
            end
            ACT_RAISE:
                motor_cap[c.motor] = (motor_cap[c.motor] + c.amt > 100) ? 100
                                     : motor_cap[c.motor] + c.amt;
            ACT_LOWER:
                motor_cap[c.motor] = (motor_cap[c.motor] > c.amt)
                                     ? motor_cap[c.motor] - c.amt : 0;
            default: ;
        endcase
        r.cap = 7'(motor_cap[c.motor]);
        return r;
    endfunction

    function automatic traction_cmd_t mk_cmd(input action_t act, input int m, input int veh,
                                             input int whl, input int axle, input int thr,
                                             input int amt);
        traction_cmd_t c;
        c.act   = act;
        c.motor = 2'(m);
        c.veh   = 16'(veh);
        c.whl   = 16'(whl);
        c.axle  = 2'(axle);
        c.thr   = 14'(thr);
        c.amt   = 8'(amt);
        return c;
    endfunction

    function automatic int pick_speed();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 2)
            return ($urandom_range(0, 1) == 1) ? 32767 : -32768;
        else if (sel < 3)
            return $urandom_range(0, 1);
        else if (sel < 6)
            return int'($signed(16'($urandom)));
        else if (sel < 8)
            return -int'($urandom_range(1, 6400));
        return $urandom_range(1, 12800);
    endfunction

    function automatic traction_cmd_t rand_cmd();
        traction_cmd_t c;
        int sel, veh, whl, span;
        sel = $urandom_range(0, 99);
        veh = pick_speed();
        sel = $urandom_range(0, 99);
        if (sel < 65)
        begin
            // wheel close to the vehicle, so slip lands around the limit
            span = (veh > 0 ? veh / 4 : 0) + 64;
            whl  = veh + $urandom_range(0, 2 * span) - span;
            if (whl > 32767)
                whl = 32767;
            if (whl < -32768)
                whl = -32768;
        end
        else
        begin
            whl = pick_speed();
        end
        c = mk_cmd(ACT_UPDATE, $urandom_range(0, MOTORS - 1), veh, whl, 0,
                   $urandom_range(0, 12288), $urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        c.axle = (sel < 45) ? AXLE_FRONT : (sel < 90) ? AXLE_REAR
                 : (sel < 98) ? 2'd2 : 2'd3;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            c.thr = ($urandom_range(0, 1) == 1) ? 14'd12288 : 14'd0;
        sel = $urandom_range(0, 99);
        if (sel < 11)
        begin
            c.act = ACT_RAISE;
            if ($urandom_range(0, 7) != 0)
                c.amt = 8'($urandom_range(0, 60));
        end
        else if (sel < 20)
        begin
            c.act = ACT_LOWER;
            if ($urandom_range(0, 7) != 0)
                c.amt = 8'($urandom_range(0, 40));
        end
        else if (sel < 22)
        begin
            c.act = ACT_NONE;
        end
        return c;
    endfunction

    // Called at a falling edge; returns at a falling edge.
    task automatic send_cmd(input traction_cmd_t c);
        in_valid       = 1'b1;
        action         = c.act;
        motor_index    = c.motor;
        vehicle_speed  = c.veh;
        wheel_speed    = c.whl;
        wheel_axle     = c.axle;
        throttle_volts = c.thr;
        amount         = c.amt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(predict_traction(c));
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid = 1'b0;
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(10, 30)) @(negedge clk);
            else
                repeat ($urandom_range(1, 4)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic wait_for_drain();
        int waited;
        waited   = 0;
        in_valid = 1'b0;
        while (expected_q.size() != 0 && waited < 50000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        limiter_regs[idx] = data;
        @(negedge clk);
    endtask

    task automatic program_limiter(input logic [15:0] lim_f, input logic [15:0] lim_r,
                                   input logic [15:0] kp_f, input logic [15:0] kd_f,
                                   input logic [15:0] kp_r, input logic [15:0] kd_r);
        wait_for_drain();
        write_reg(REG_SLIP_LIMIT_FRONT, lim_f);
        write_reg(REG_SLIP_LIMIT_REAR, lim_r);
        write_reg(REG_PROP_GAIN_FRONT, kp_f);
        write_reg(REG_DERIV_GAIN_FRONT, kd_f);
        write_reg(REG_PROP_GAIN_REAR, kp_r);
        write_reg(REG_DERIV_GAIN_REAR, kd_r);
        cfg_valid = 1'b0;
    endtask

    task automatic run_traffic(input int n);
        repeat (n) send_cmd(rand_cmd());
    endtask

    // saturation and floor of the caps, action three; leaves every cap nonzero
    task automatic test_cap_limits();
        send_cmd(mk_cmd(ACT_RAISE, 0, 0, 0, 0, 0, 255));
        send_cmd(mk_cmd(ACT_LOWER, 0, 0, 0, 0, 0, 255));
        send_cmd(mk_cmd(ACT_RAISE, 1, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(ACT_RAISE, 1, 0, 0, 0, 0, 60));
        send_cmd(mk_cmd(ACT_RAISE, 1, 0, 0, 0, 0, 60));
        send_cmd(mk_cmd(ACT_LOWER, 1, 0, 0, 0, 0, 1));
        send_cmd(mk_cmd(ACT_NONE, 1, -32768, 32767, 3, 12288, 255));
        send_cmd(mk_cmd(ACT_RAISE, 0, 0, 0, 0, 0, 100));
        send_cmd(mk_cmd(ACT_RAISE, 2, 0, 0, 0, 0, 100));
        send_cmd(mk_cmd(ACT_RAISE, 3, 0, 0, 0, 0, 100));
    endtask

    // speed and throttle extremes, unknown axles, negative product, slip saturation
    task automatic test_update_corners();
        send_cmd(mk_cmd(ACT_UPDATE, 0, 0, 100, 0, 12288, 0));
        send_cmd(mk_cmd(ACT_UPDATE, 0, -32768, 32767, 1, 12288, 0));
        send_cmd(mk_cmd(ACT_UPDATE, 1, 1, 32767, 0, 6000, 0));
        send_cmd(mk_cmd(ACT_UPDATE, 2, 1, -32768, 1, 12288, 0));
        send_cmd(mk_cmd(ACT_UPDATE, 3, 32767, -32768, 0, 12288, 0));
        send_cmd(mk_cmd(ACT_UPDATE, 2, 256, 512, 2, 12288, 0));
        send_cmd(mk_cmd(ACT_UPDATE, 3, 256, 512, 3, 12288, 0));
        send_cmd(mk_cmd(ACT_UPDATE, 1, 256, 256, 0, 12288, 0));
        send_cmd(mk_cmd(ACT_UPDATE, 1, 256, 255, 1, 12288, 0));
        send_cmd(mk_cmd(ACT_UPDATE, 3, -1, 0, 0, 12288, 0));
        send_cmd(mk_cmd(ACT_UPDATE, 2, 32767, 32767, 2, 0, 0));
        send_cmd(mk_cmd(ACT_UPDATE, 0, 0, -32768, 1, 12288, 0));
    endtask

    task automatic test_reset_settings();
        run_traffic(240);
    endtask

    task automatic test_zero_settings();
        program_limiter(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_traffic(240);
    endtask

    task automatic test_full_settings();
        program_limiter(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_traffic(240);
    endtask

    task automatic test_tuned_settings();
        program_limiter(16'd2400, 16'd1800, 16'd384, 16'd128, 16'd640, 16'd300);
        run_traffic(240);
    endtask

    task automatic test_random_settings();
        repeat (2)
        begin
            program_limiter(16'($urandom_range(0, 4000)), 16'($urandom),
                            16'($urandom_range(0, 2048)), 16'($urandom),
                            16'($urandom), 16'($urandom_range(0, 1024)));
            run_traffic(240);
        end
    endtask

    // receiver stall pattern: always ready, coin flip, mostly stalled, stalled every third
    initial
    begin
        out_ready = 1'b0;
        sink_left = 0;
        sink_tick = 0;
        sink_mode = 0;
    end

    always @(negedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode = $urandom_range(0, 3);
            sink_left = $urandom_range(50, 400);
        end
        sink_left--;
        sink_tick++;
        case (sink_mode)
            0: out_ready = 1'b1;
            1: out_ready = ($urandom_range(0, 1) == 1);
            2: out_ready = ($urandom_range(0, 4) == 0);
            default: out_ready = (sink_tick % 3) != 0;
        endcase
    end

    always @(posedge clk)
    begin : result_check
        drive_result_t want;
        drive_result_t got;
        got = {out_motor, drive_level, slip_percent, control_active, cap_percent};
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: motor %0d level %0d slip %0d",
                             got.motor, got.level, $signed(got.slip));
            end
            else
            begin
                want = expected_q.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected motor %0d level %0d slip %0d ",
                                  "active %0d cap %0d, got motor %0d level %0d slip %0d ",
                                  "active %0d cap %0d"},
                                 want.motor, want.level, $signed(want.slip), want.active,
                                 want.cap, got.motor, got.level, $signed(got.slip),
                                 got.active, got.cap);
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("wheel_slip_traction_limiter_top test failed");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = ACT_UPDATE;
        motor_index    = '0;
        vehicle_speed  = '0;
        wheel_speed    = '0;
        wheel_axle     = AXLE_FRONT;
        throttle_volts = '0;
        amount         = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_SLIP_LIMIT_FRONT;
        cfg_data       = '0;
        mismatches     = 0;
        burst_left     = 5;
        limiter_regs[REG_SLIP_LIMIT_FRONT] = SLIP_LIMIT_RESET;
        limiter_regs[REG_SLIP_LIMIT_REAR]  = SLIP_LIMIT_RESET;
        limiter_regs[REG_PROP_GAIN_FRONT]  = PROP_GAIN_RESET;
        limiter_regs[REG_DERIV_GAIN_FRONT] = DERIV_GAIN_RESET;
        limiter_regs[REG_PROP_GAIN_REAR]   = PROP_GAIN_RESET;
        limiter_regs[REG_DERIV_GAIN_REAR]  = DERIV_GAIN_RESET;
        for (int i = 0; i < MOTORS; i++)
        begin
            stored_error[i] = 0;
            motor_cap[i]    = 0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_cap_limits();
        test_update_corners();
        test_reset_settings();
        test_zero_settings();
        test_full_settings();
        test_tuned_settings();
        test_random_settings();

        wait_for_drain();
        if (expected_q.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("wheel_slip_traction_limiter_top test passed");
        else
            $display("wheel_slip_traction_limiter_top test failed");
        $finish;
    end

endmodule
